/* design/sawrs_pkg.sv */
// ----------------------------------------------------------------------------
// sawrs_pkg: shared types and constants
// Widths, codes and structs for the stop-and-wait result sender.
// ----------------------------------------------------------------------------
package sawrs_pkg;

    localparam int NUM_W      = 5;   // packet index
    localparam int ATT_W      = 8;   // attempt counter
    localparam int TIME_W     = 32;  // millisecond timestamps
    localparam int MS16_W     = 16;  // 16 bit millisecond settings
    localparam int LINK_W     = 20;  // link timeout setting
    localparam int DRV_W      = 16;  // drive acknowledge divider
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int WHEELS_DEF = 4;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_OK   = 2'd1,
        KIND_NG   = 2'd2,
        KIND_CMD  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LOCAL  = 2'd1,
        PH_REMOTE = 2'd2,
        PH_GUARD  = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL_TO   = 3'd0,
        CFG_REMOTE_TO  = 3'd1,
        CFG_GUARD      = 3'd2,
        CFG_MAX_RETRY  = 3'd3,
        CFG_LINK_TO    = 3'd4,
        CFG_DRIVE_INT  = 3'd5,
        CFG_LED_PULSE  = 3'd6,
        CFG_REPLY_EN   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [MS16_W-1:0] local_response_timeout_ms;
        logic [MS16_W-1:0] remote_ack_timeout_ms;
        logic [MS16_W-1:0] guard_ms;
        logic [ATT_W-1:0]  max_retries;
        logic [LINK_W-1:0] link_timeout_ms;
        logic [DRV_W-1:0]  drive_ack_every;
        logic [MS16_W-1:0] led_hold_ms;
        logic              reply_enable;
    } cfg_t;

    typedef struct packed {
        kind_t            kind;
        logic             results_ready;
        logic             chassis_active;
        logic             ack_present;
        logic [NUM_W-1:0] ack_number;
        logic             abort_request;
        logic             drive_done;
    } item_t;

    typedef struct packed {
        logic             send_valid;
        logic [NUM_W-1:0] send_number;
        logic [ATT_W-1:0] send_attempt;
        logic             clear_ready;
        logic             sequence_failed;
        logic             sequence_done;
        logic             stop_request;
        logic             drive_ack;
        logic             led;
        logic             busy_res;
    } result_t;

endpackage

/* design/sawrs_item_if.sv */
// ----------------------------------------------------------------------------
// sawrs_item_if: input event channel
// Valid/ready channel carrying one event item.
// ----------------------------------------------------------------------------
interface sawrs_item_if;
    import sawrs_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic             results_ready;
    logic             chassis_active;
    logic             ack_present;
    logic [NUM_W-1:0] ack_number;
    logic             abort_request;
    logic             drive_done;

    modport source
    (
        output valid, kind, results_ready, chassis_active, ack_present,
               ack_number, abort_request, drive_done,
        input  ready
    );

    modport sink
    (
        input  valid, kind, results_ready, chassis_active, ack_present,
               ack_number, abort_request, drive_done,
        output ready
    );
endinterface

/* design/sawrs_result_if.sv */
// ----------------------------------------------------------------------------
// sawrs_result_if: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface sawrs_result_if;
    import sawrs_pkg::*;

    logic             valid;
    logic             ready;
    logic             send_valid;
    logic [NUM_W-1:0] send_number;
    logic [ATT_W-1:0] send_attempt;
    logic             clear_ready;
    logic             sequence_failed;
    logic             sequence_done;
    logic             stop_request;
    logic             drive_ack;
    logic             led;
    logic             busy_res;

    modport source
    (
        output valid, send_valid, send_number, send_attempt, clear_ready,
               sequence_failed, sequence_done, stop_request, drive_ack, led,
               busy_res,
        input  ready
    );

    modport sink
    (
        input  valid, send_valid, send_number, send_attempt, clear_ready,
               sequence_failed, sequence_done, stop_request, drive_ack, led,
               busy_res,
        output ready
    );
endinterface

/* design/sawrs_cfg_if.sv */
// ----------------------------------------------------------------------------
// sawrs_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface sawrs_cfg_if;
    import sawrs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source
    (
        output valid, index, data,
        input  ready
    );

    modport sink
    (
        input  valid, index, data,
        output ready
    );
endinterface

/* design/stop_and_wait_result_sender.sv */
// Path: an accepted request waits in the input register, goes through the event
//   logic when the result register is free or being emptied, and lands there.
// Throughput: one item per cycle; the input register refills in the cycle it
//   drains, so only a stalled result channel holds the input side back.
// Reset (rst_n low, asynchronous): sequencer idle, time and counters zero,
//   LED off, settings back to their defaults, both channel registers empty.
// ----------------------------------------------------------------------------
// stop_and_wait_result_sender: stop-and-wait result sender
// Sends packets 0..WHEELS with retries, plus link watchdog, drive
// acknowledge divider and activity LED, driven by tick and event items.
// ----------------------------------------------------------------------------
module stop_and_wait_result_sender
#(
    parameter int WHEELS = sawrs_pkg::WHEELS_DEF   // 1..31, index of done marker
)
(
    input  logic            clk,
    input  logic            rst_n,
    sawrs_item_if.sink      items,
    sawrs_result_if.source  results,
    sawrs_cfg_if.sink       cfg
);
    import sawrs_pkg::*;

    // input register
    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    cfg_t    cfg_val;
    result_t core_res;
    logic    advance;   // held item goes through the event logic this cycle
    logic    take_in;

    // the held item moves on when the result register is free or being emptied
    assign advance     = in_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready = !in_valid_reg || advance;
    assign take_in     = items.valid && items.ready;

    always_comb
    begin
        in_valid_next  = take_in || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !results.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg.kind           <= kind_t'(items.kind);
            in_item_reg.results_ready  <= items.results_ready;
            in_item_reg.chassis_active <= items.chassis_active;
            in_item_reg.ack_present    <= items.ack_present;
            in_item_reg.ack_number     <= items.ack_number;
            in_item_reg.abort_request  <= items.abort_request;
            in_item_reg.drive_done     <= items.drive_done;
        end
        if (advance)
            out_res_reg <= core_res;
    end

    sawrs_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    sawrs_core
    #(
        .WHEELS (WHEELS)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg_val (cfg_val),
        .result  (core_res)
    );

    assign results.valid           = out_valid_reg;
    assign results.send_valid      = out_res_reg.send_valid;
    assign results.send_number     = out_res_reg.send_number;
    assign results.send_attempt    = out_res_reg.send_attempt;
    assign results.clear_ready     = out_res_reg.clear_ready;
    assign results.sequence_failed = out_res_reg.sequence_failed;
    assign results.sequence_done   = out_res_reg.sequence_done;
    assign results.stop_request    = out_res_reg.stop_request;
    assign results.drive_ack       = out_res_reg.drive_ack;
    assign results.led             = out_res_reg.led;
    assign results.busy_res        = out_res_reg.busy_res;
endmodule

/* design/sawrs_cfg.sv */
// ----------------------------------------------------------------------------
// sawrs_cfg: configuration register bank
// Holds the eight settings; one write request per cycle, always ready.
// ----------------------------------------------------------------------------
module sawrs_cfg
(
    input  logic              clk,
    input  logic              rst_n,
    sawrs_cfg_if.sink         cfg,
    output sawrs_pkg::cfg_t   cfg_val
);
    import sawrs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_val   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_LOCAL_TO:  cfg_next.local_response_timeout_ms = cfg.data[MS16_W-1:0];
                CFG_REMOTE_TO: cfg_next.remote_ack_timeout_ms     = cfg.data[MS16_W-1:0];
                CFG_GUARD:     cfg_next.guard_ms                  = cfg.data[MS16_W-1:0];
                CFG_MAX_RETRY: cfg_next.max_retries               = cfg.data[ATT_W-1:0];
                CFG_LINK_TO:   cfg_next.link_timeout_ms           = cfg.data[LINK_W-1:0];
                CFG_DRIVE_INT: cfg_next.drive_ack_every           = cfg.data[DRV_W-1:0];
                CFG_LED_PULSE: cfg_next.led_hold_ms               = cfg.data[MS16_W-1:0];
                CFG_REPLY_EN:  cfg_next.reply_enable              = cfg.data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_response_timeout_ms <= MS16_W'(200);
            cfg_reg.remote_ack_timeout_ms     <= MS16_W'(500);
            cfg_reg.guard_ms                  <= MS16_W'(50);
            cfg_reg.max_retries               <= ATT_W'(3);
            cfg_reg.link_timeout_ms           <= LINK_W'(1000);
            cfg_reg.drive_ack_every           <= DRV_W'(10);
            cfg_reg.led_hold_ms               <= MS16_W'(50);
            cfg_reg.reply_enable              <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

/* design/sawrs_core.sv */
// ----------------------------------------------------------------------------
// sawrs_core: sender state and single-pass event logic
// Applies one event to the sequencer, watchdog, divider and LED state.
// ----------------------------------------------------------------------------
module sawrs_core
#(
    parameter int WHEELS = sawrs_pkg::WHEELS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  sawrs_pkg::item_t   item,
    input  sawrs_pkg::cfg_t    cfg_val,
    output sawrs_pkg::result_t result
);
    import sawrs_pkg::*;

    phase_t             phase_reg,    phase_next;
    logic [NUM_W-1:0]   pkt_reg,      pkt_next;
    logic [ATT_W-1:0]   att_reg,      att_next;
    logic [TIME_W-1:0]  started_reg,  started_next;
    logic [TIME_W-1:0]  allowed_reg,  allowed_next;
    logic [TIME_W-1:0]  now_reg,      now_next;
    logic [TIME_W-1:0]  now1_reg,     now1_next;   // always now_reg + 1
    logic [TIME_W-1:0]  activity_reg, activity_next;
    logic [DRV_W-1:0]   drive_reg,    drive_next;
    logic               led_reg,      led_next;
    logic [TIME_W-1:0]  led_off_reg,  led_off_next;

    logic ev_send, ev_clear, ev_fail, ev_done, ev_stop, ev_dack;

    always_comb
    begin
        logic [TIME_W-1:0] diff_led;
        logic [TIME_W-1:0] diff_link;
        logic [TIME_W-1:0] diff_start;
        logic [TIME_W-1:0] diff_allow;
        logic [DRV_W-1:0]  lim;
        logic [DRV_W-1:0]  dp1;
        logic              retry;

        phase_next    = phase_reg;
        pkt_next      = pkt_reg;
        att_next      = att_reg;
        started_next  = started_reg;
        allowed_next  = allowed_reg;
        now_next      = now_reg;
        now1_next     = now1_reg;
        activity_next = activity_reg;
        drive_next    = drive_reg;
        led_next      = led_reg;
        led_off_next  = led_off_reg;
        ev_send  = 1'b0;
        ev_clear = 1'b0;
        ev_fail  = 1'b0;
        ev_done  = 1'b0;
        ev_stop  = 1'b0;
        ev_dack  = 1'b0;
        retry    = 1'b0;
        diff_led   = now1_reg - led_off_reg;
        diff_link  = now1_reg - activity_reg;
        lim        = (cfg_val.drive_ack_every == '0) ? DRV_W'(1)
                                                      : cfg_val.drive_ack_every;
        dp1        = drive_reg + DRV_W'(1);

        unique case (item.kind)
            KIND_TICK:
            begin
                now_next  = now1_reg;
                now1_next = now1_reg + TIME_W'(1);

                if (led_reg && !diff_led[TIME_W-1])
                    led_next = 1'b0;

                // link watchdog
                if (diff_link > TIME_W'(cfg_val.link_timeout_ms))
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        phase_next   = PH_IDLE;
                        pkt_next     = '0;
                        att_next     = '0;
                        started_next = '0;
                        allowed_next = '0;
                        ev_clear     = 1'b1;
                    end
                    ev_stop       = item.chassis_active;
                    activity_next = now1_reg;
                end

                if (phase_next == PH_IDLE && item.results_ready)
                begin
                    pkt_next     = '0;
                    att_next     = '0;
                    phase_next   = PH_GUARD;
                    allowed_next = now1_reg;
                end

                diff_start = now1_reg - started_next;
                diff_allow = now1_reg - allowed_next;

                unique case (phase_next)
                    PH_LOCAL:
                        retry = diff_start >= TIME_W'(cfg_val.local_response_timeout_ms);
                    PH_REMOTE:
                        retry = diff_start >= TIME_W'(cfg_val.remote_ack_timeout_ms);
                    PH_GUARD:
                    begin
                        if (!diff_allow[TIME_W-1])
                        begin
                            if (att_next > cfg_val.max_retries)
                            begin
                                ev_fail = 1'b1;
                            end
                            else
                            begin
                                if (att_next != '1)
                                    att_next = att_next + ATT_W'(1);
                                ev_send      = 1'b1;
                                phase_next   = PH_LOCAL;
                                started_next = now1_reg;
                            end
                        end
                    end
                    default: retry = 1'b0;
                endcase
            end

            KIND_OK:
            begin
                diff_start = '0;
                diff_allow = '0;
                if (phase_reg == PH_LOCAL)
                begin
                    phase_next   = PH_REMOTE;
                    started_next = now_reg;
                end
            end

            KIND_NG:
            begin
                diff_start = '0;
                diff_allow = '0;
                retry      = (phase_reg == PH_LOCAL);
            end

            default:
            begin
                diff_start    = '0;
                diff_allow    = '0;
                activity_next = now_reg;
                led_next      = 1'b1;
                led_off_next  = now_reg + TIME_W'(cfg_val.led_hold_ms);
                if (item.abort_request)
                begin
                    phase_next   = PH_IDLE;
                    pkt_next     = '0;
                    att_next     = '0;
                    started_next = '0;
                    allowed_next = '0;
                end
                if (item.ack_present && phase_next == PH_REMOTE
                    && item.ack_number == pkt_next)
                begin
                    if (item.ack_number == NUM_W'(WHEELS))
                    begin
                        ev_clear     = 1'b1;
                        ev_done      = 1'b1;
                        phase_next   = PH_IDLE;
                        pkt_next     = '0;
                        att_next     = '0;
                        started_next = '0;
                        allowed_next = '0;
                    end
                    else
                    begin
                        pkt_next     = pkt_next + NUM_W'(1);
                        att_next     = '0;
                        phase_next   = PH_GUARD;
                        allowed_next = now_reg + TIME_W'(cfg_val.guard_ms);
                    end
                end
                if (item.drive_done)
                begin
                    drive_next = dp1;
                    if (dp1 >= lim || dp1 == '0)
                    begin
                        drive_next = '0;
                        ev_dack    = 1'b1;
                    end
                end
            end
        endcase

        // timeout or NG: back off, or give up when attempts are spent
        if (retry)
        begin
            if (att_next > cfg_val.max_retries)
            begin
                ev_fail = 1'b1;
            end
            else
            begin
                phase_next   = PH_GUARD;
                allowed_next = now_next + TIME_W'(cfg_val.guard_ms);
            end
        end

        if (ev_fail)
        begin
            ev_clear     = 1'b1;
            phase_next   = PH_IDLE;
            pkt_next     = '0;
            att_next     = '0;
            started_next = '0;
            allowed_next = '0;
        end
    end

    always_comb
    begin
        result.send_valid      = ev_send & cfg_val.reply_enable;
        result.send_number     = result.send_valid ? pkt_next : '0;
        result.send_attempt    = result.send_valid ? att_next : '0;
        result.clear_ready     = ev_clear;
        result.sequence_failed = ev_fail;
        result.sequence_done   = ev_done;
        result.stop_request    = ev_stop;
        result.drive_ack       = ev_dack & cfg_val.reply_enable;
        result.led             = led_next;
        result.busy_res        = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            pkt_reg      <= '0;
            att_reg      <= '0;
            started_reg  <= '0;
            allowed_reg  <= '0;
            now_reg      <= '0;
            now1_reg     <= TIME_W'(1);
            activity_reg <= '0;
            drive_reg    <= '0;
            led_reg      <= 1'b0;
            led_off_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            pkt_reg      <= pkt_next;
            att_reg      <= att_next;
            started_reg  <= started_next;
            allowed_reg  <= allowed_next;
            now_reg      <= now_next;
            now1_reg     <= now1_next;
            activity_reg <= activity_next;
            drive_reg    <= drive_next;
            led_reg      <= led_next;
            led_off_reg  <= led_off_next;
        end
    end
endmodule

/* sim/stop_and_wait_result_sender_tb.sv */
// ----------------------------------------------------------------------------
// stop_and_wait_result_sender_tb: self-checking bench for the result sender
// Drives tick, local OK/NG and command requests with random idling on both
// channels. A behavioural copy of the sender predicts one result per request,
// and every result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module stop_and_wait_result_sender_tb;
    import sawrs_pkg::*;

    localparam int WHEELS = WHEELS_DEF;

    logic clk = 1'b0;
    logic rst_n;

    sawrs_item_if   item_ch();
    sawrs_result_if res_ch();
    sawrs_cfg_if    cfg_ch();

    stop_and_wait_result_sender #(.WHEELS(WHEELS)) u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Behavioural sender: settings, sequencer, watchdog, divider, LED
    // ------------------------------------------------------------------
    cfg_t         settings;
    phase_t       ph;
    logic [4:0]   pkt_no;
    logic [7:0]   tries;
    logic [31:0]  sent_at;      // start of the current wait
    logic [31:0]  send_after;   // end of guard time
    logic [31:0]  clock_ms;
    logic [31:0]  heard_at;     // last command seen on the link
    logic [15:0]  drive_count;
    logic         led_on;
    logic [31:0]  led_until;

    result_t      next_result;  // built up while a request is applied
    result_t      pending_results[$];
    int unsigned  fault_count = 0;
    bit           no_gaps = 1'b0;

    function automatic cfg_t make_settings(int unsigned lrt, int unsigned rat,
                                           int unsigned grd, int unsigned mr,
                                           int unsigned lnk, int unsigned drv,
                                           int unsigned ledp, int unsigned en);
        cfg_t c;
        c.local_response_timeout_ms = 16'(lrt);
        c.remote_ack_timeout_ms     = 16'(rat);
        c.guard_ms                  = 16'(grd);
        c.max_retries               = 8'(mr);
        c.link_timeout_ms           = 20'(lnk);
        c.drive_ack_every           = 16'(drv);
        c.led_hold_ms               = 16'(ledp);
        c.reply_enable              = 1'(en);
        return c;
    endfunction

    function void clear_sequence();
        ph         = PH_IDLE;
        pkt_no     = '0;
        tries      = '0;
        sent_at    = '0;
        send_after = '0;
    endfunction

    function void give_up();
        next_result.clear_ready     = 1'b1;
        next_result.sequence_failed = 1'b1;
        clear_sequence();
    endfunction

    function void arm_retry();
        if (tries > settings.max_retries)
            give_up();
        else
        begin
            ph         = PH_GUARD;
            send_after = clock_ms + settings.guard_ms;
        end
    endfunction

    // true once clock_ms has reached t (modulo 2^32, half range ahead)
    function automatic bit due(logic [31:0] t);
        logic [31:0] d;
        d = clock_ms - t;
        return !d[31];
    endfunction

    function void reset_model();
        settings    = make_settings(200, 500, 50, 3, 1000, 10, 50, 1);
        clear_sequence();
        clock_ms    = '0;
        heard_at    = '0;
        drive_count = '0;
        led_on      = 1'b0;
        led_until   = '0;
    endfunction

    // Apply one accepted request; the outcome lands in next_result.
    function void advance_sender(item_t it);
        logic [15:0] lim;
        next_result = '0;
        case (it.kind)
            KIND_TICK:
            begin
                clock_ms = clock_ms + 32'd1;
                if (led_on && due(led_until))
                    led_on = 1'b0;
                // watchdog: long silence drops the sequence
                if (clock_ms - heard_at > settings.link_timeout_ms)
                begin
                    if (ph != PH_IDLE)
                    begin
                        clear_sequence();
                        next_result.clear_ready = 1'b1;
                    end
                    if (it.chassis_active)
                        next_result.stop_request = 1'b1;
                    heard_at = clock_ms;
                end
                if (ph == PH_IDLE && it.results_ready)
                begin
                    pkt_no     = '0;
                    tries      = '0;
                    ph         = PH_GUARD;
                    send_after = clock_ms;
                end
                if (ph == PH_LOCAL)
                begin
                    if (clock_ms - sent_at >= settings.local_response_timeout_ms)
                        arm_retry();
                end
                else if (ph == PH_REMOTE)
                begin
                    if (clock_ms - sent_at >= settings.remote_ack_timeout_ms)
                        arm_retry();
                end
                else if (ph == PH_GUARD && due(send_after))
                begin
                    if (tries > settings.max_retries)
                        give_up();
                    else
                    begin
                        if (tries != 8'hFF)
                            tries = tries + 8'd1;
                        if (settings.reply_enable)
                        begin
                            next_result.send_valid   = 1'b1;
                            next_result.send_number  = pkt_no;
                            next_result.send_attempt = tries;
                        end
                        ph      = PH_LOCAL;
                        sent_at = clock_ms;
                    end
                end
            end
            KIND_OK:
            begin
                if (ph == PH_LOCAL)
                begin
                    ph      = PH_REMOTE;
                    sent_at = clock_ms;
                end
            end
            KIND_NG:
            begin
                if (ph == PH_LOCAL)
                    arm_retry();
            end
            default:
            begin
                heard_at  = clock_ms;
                led_on    = 1'b1;
                led_until = clock_ms + settings.led_hold_ms;
                if (it.abort_request)
                    clear_sequence();
                if (it.ack_present && ph == PH_REMOTE && it.ack_number == pkt_no)
                begin
                    if (it.ack_number == WHEELS)
                    begin
                        next_result.clear_ready   = 1'b1;
                        next_result.sequence_done = 1'b1;
                        clear_sequence();
                    end
                    else
                    begin
                        pkt_no     = pkt_no + 5'd1;
                        tries      = '0;
                        ph         = PH_GUARD;
                        send_after = clock_ms + settings.guard_ms;
                    end
                end
                if (it.drive_done)
                begin
                    lim = (settings.drive_ack_every == '0) ? 16'd1
                                                           : settings.drive_ack_every;
                    drive_count = drive_count + 16'd1;
                    if (drive_count >= lim || drive_count == '0)
                    begin
                        drive_count = '0;
                        if (settings.reply_enable)
                            next_result.drive_ack = 1'b1;
                    end
                end
            end
        endcase
        next_result.led      = led_on;
        next_result.busy_res = (ph != PH_IDLE);
    endfunction

    // ------------------------------------------------------------------
    // Request builders: unused fields carry random noise
    // ------------------------------------------------------------------
    function automatic item_t noise_item();
        item_t it;
        it.kind           = kind_t'($urandom_range(0, 3));
        it.results_ready  = 1'($urandom_range(0, 1));
        it.chassis_active = 1'($urandom_range(0, 1));
        it.ack_present    = 1'($urandom_range(0, 1));
        it.ack_number     = 5'($urandom_range(0, 16));
        it.abort_request  = 1'($urandom_range(0, 1));
        it.drive_done     = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic item_t make_tick(bit rdy, bit act);
        item_t it;
        it                = noise_item();
        it.kind           = KIND_TICK;
        it.results_ready  = rdy;
        it.chassis_active = act;
        return it;
    endfunction

    function automatic item_t make_reply(kind_t k);
        item_t it;
        it      = noise_item();
        it.kind = k;
        return it;
    endfunction

    function automatic item_t make_cmd(bit ackp, logic [4:0] num, bit abrt, bit drv);
        item_t it;
        it               = noise_item();
        it.kind          = KIND_CMD;
        it.ack_present   = ackp;
        it.ack_number    = num;
        it.abort_request = abrt;
        it.drive_done    = drv;
        return it;
    endfunction

    // Mostly the request that moves the sequence on, sometimes not.
    function automatic item_t steer_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_IDLE:
                return (r < 80) ? make_tick($urandom_range(0, 3) != 0,
                                            1'($urandom_range(0, 1)))
                                : noise_item();
            PH_LOCAL:
                if (r < 65)
                    return make_reply(KIND_OK);
                else if (r < 80)
                    return make_reply(KIND_NG);
                else
                    return make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            PH_REMOTE:
                if (r < 70)
                    return make_cmd(1'b1, pkt_no, $urandom_range(0, 39) == 0,
                                    1'($urandom_range(0, 1)));
                else if (r < 80)
                    return make_cmd(1'b1, 5'($urandom_range(0, 16)), 1'b0,
                                    1'($urandom_range(0, 1)));
                else
                    return make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            default:
                return (r < 90) ? make_tick(1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)))
                                : noise_item();
        endcase
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function void note_failure(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic string fmt_result(result_t r);
        return $sformatf({"sv=%0d num=%0d att=%0d clr=%0d fail=%0d done=%0d ",
                          "stop=%0d dack=%0d led=%0d busy=%0d"},
                         r.send_valid, r.send_number, r.send_attempt, r.clear_ready,
                         r.sequence_failed, r.sequence_done, r.stop_request,
                         r.drive_ack, r.led, r.busy_res);
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------

    // One request; valid stays high into the next call unless a gap follows.
    task automatic push_event(item_t it);
        int unsigned gap;
        item_ch.valid          <= 1'b1;
        item_ch.kind           <= it.kind;
        item_ch.results_ready  <= it.results_ready;
        item_ch.chassis_active <= it.chassis_active;
        item_ch.ack_present    <= it.ack_present;
        item_ch.ack_number     <= it.ack_number;
        item_ch.abort_request  <= it.abort_request;
        item_ch.drive_done     <= it.drive_done;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        advance_sender(it);
        pending_results.push_back(next_result);
        gap = no_gaps ? 0 : idle_len();
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold requests back until every result is in, then allow for the input
    // and result registers to empty.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all eight registers back to back, after settling first.
    task automatic load_settings(cfg_t c);
        cfg_idx_t    idx;
        logic [19:0] val;
        settle();
        for (int i = 0; i < 8; i++)
        begin
            idx = cfg_idx_t'(i);
            case (idx)
                CFG_LOCAL_TO:  val = 20'(c.local_response_timeout_ms);
                CFG_REMOTE_TO: val = 20'(c.remote_ack_timeout_ms);
                CFG_GUARD:     val = 20'(c.guard_ms);
                CFG_MAX_RETRY: val = 20'(c.max_retries);
                CFG_LINK_TO:   val = c.link_timeout_ms;
                CFG_DRIVE_INT: val = 20'(c.drive_ack_every);
                CFG_LED_PULSE: val = 20'(c.led_hold_ms);
                default:       val = 20'(c.reply_enable);
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= val;
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        settings = c;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: stale ack while idle, first send, NG into default guard.
    task automatic test_power_on_defaults();
        push_event(make_cmd(1'b1, 5'd16, 1'b0, 1'b1));
        push_event(make_tick(1'b1, 1'b1));
        push_event(make_reply(KIND_NG));
    endtask

    // Tight timeouts, no retries: abort, ack, out-of-turn OK/NG, both timeouts.
    task automatic test_short_sequence();
        load_settings(make_settings(1, 1, 0, 0, 1000000, 0, 0, 1));
        push_event(make_cmd(1'b0, 5'd0, 1'b1, 1'b1));   // abort; zero interval acks
        push_event(make_tick(1'b1, 1'b0));               // packet 0 out
        push_event(make_reply(KIND_OK));
        push_event(make_cmd(1'b1, 5'd0, 1'b0, 1'b0));   // ack moves to packet 1
        push_event(make_reply(KIND_OK));                 // in guard: ignored
        push_event(make_tick(1'b0, 1'b0));               // packet 1 out
        push_event(make_tick(1'b0, 1'b0));               // no local reply: fails
        push_event(make_tick(1'b1, 1'b0));
        push_event(make_reply(KIND_OK));
        push_event(make_tick(1'b0, 1'b0));               // no remote ack: fails
        push_event(make_reply(KIND_NG));                 // idle: ignored
    endtask

    // Zero link timeout, replies suppressed, widest timers.
    task automatic test_link_watchdog();
        load_settings(make_settings(65535, 65535, 65535, 255, 0, 65535, 65535, 0));
        push_event(make_tick(1'b1, 1'b1));   // idle loss: stop only, then start
        push_event(make_tick(1'b1, 1'b1));   // busy loss: clear, stop, restart
        push_event(make_cmd(1'b0, 5'd0, 1'b0, 1'b1));
        push_event(make_tick(1'b0, 1'b0));
    endtask

    // Count left above a newly lowered interval restarts and acknowledges.
    task automatic test_drive_divider();
        push_event(make_cmd(1'b0, 5'd0, 1'b0, 1'b1));
        push_event(make_cmd(1'b0, 5'd0, 1'b0, 1'b1));
        load_settings(make_settings(10, 10, 2, 3, 1000000, 2, 3, 1));
        push_event(make_cmd(1'b0, 5'd0, 1'b0, 1'b1));
        push_event(make_cmd(1'b0, 5'd0, 1'b0, 1'b1));
        push_event(make_cmd(1'b0, 5'd0, 1'b0, 1'b1));
    endtask

    // Endless retries: attempt number runs up to 255 and stays there.
    task automatic test_attempt_saturation();
        load_settings(make_settings(0, 0, 0, 255, 1000000, 10, 5, 1));
        push_event(make_tick(1'b1, 1'b0));
        repeat (530)
            push_event(make_tick(1'b0, 1'($urandom_range(0, 1))));
        push_event(make_cmd(1'b0, 5'd0, 1'b1, 1'b0));
    endtask

    // Mostly well-formed sequences with random content, some noise.
    task automatic test_random_traffic();
        cfg_t c;
        for (int k = 0; k < 4; k++)
        begin
            c = make_settings($urandom_range(0, 8), $urandom_range(0, 10),
                              $urandom_range(0, 4),
                              ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 3),
                              ($urandom_range(0, 3) == 0) ? 1000000 : $urandom_range(4, 40),
                              (k == 0) ? 1 : $urandom_range(1, 6),
                              $urandom_range(0, 6), (k == 2) ? 0 : 1);
            load_settings(c);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 100; i++)
            begin
                push_event(($urandom_range(0, 99) < 85) ? steer_item() : noise_item());
                // sender holds off until the result side has caught up
                if ((k == 0 && i == 50) || $urandom_range(0, 59) == 0)
                    settle();
            end
            no_gaps = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and stimulus
    // ------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        reset_model();
        rst_n                  <= 1'b0;
        item_ch.valid          <= 1'b0;
        item_ch.kind           <= KIND_TICK;
        item_ch.results_ready  <= 1'b0;
        item_ch.chassis_active <= 1'b0;
        item_ch.ack_present    <= 1'b0;
        item_ch.ack_number     <= '0;
        item_ch.abort_request  <= 1'b0;
        item_ch.drive_done     <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= CFG_LOCAL_TO;
        cfg_ch.data            <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_defaults();
        test_short_sequence();
        test_link_watchdog();
        test_drive_divider();
        test_attempt_saturation();
        test_random_traffic();

        settle();
        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side back-pressure: runs of ready, mostly short stalls, the odd
    // long stall and occasional long stretches with none.
    initial
    begin : result_ready_drive
        int unsigned run;
        int unsigned hold;
        int unsigned r;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            res_ch.ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                              : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 20)
                hold = 0;
            else if (r < 75)
                hold = $urandom_range(1, 2);
            else if (r < 94)
                hold = $urandom_range(3, 6);
            else
                hold = $urandom_range(15, 40);
            if (hold != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // Each accepted result against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        result_t seen;
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen.send_valid      = res_ch.send_valid;
            seen.send_number     = res_ch.send_number;
            seen.send_attempt    = res_ch.send_attempt;
            seen.clear_ready     = res_ch.clear_ready;
            seen.sequence_failed = res_ch.sequence_failed;
            seen.sequence_done   = res_ch.sequence_done;
            seen.stop_request    = res_ch.stop_request;
            seen.drive_ack       = res_ch.drive_ack;
            seen.led             = res_ch.led;
            seen.busy_res        = res_ch.busy_res;
            if (pending_results.size() == 0)
                note_failure({"unexpected result: ", fmt_result(seen)});
            else
            begin
                want = pending_results.pop_front();
                if (seen !== want)
                    note_failure({"result mismatch\n  expected: ", fmt_result(want),
                                  "\n  actual:   ", fmt_result(seen)});
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule
